>>> rtl/utp_pkg.sv
// Shared types, codes and helper functions for the text-to-uint32 parser.
// No dependencies; every other file of the block imports this package.
package utp_pkg;

    localparam int unsigned CharW = 8;
    localparam int unsigned NumW  = 32;

    // Character codes used by the parser.
    localparam logic [CharW-1:0] ChNul   = 8'h00;
    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] ChTab   = 8'h09;
    localparam logic [CharW-1:0] ChCr    = 8'h0D;
    localparam logic [CharW-1:0] ChLf    = 8'h0A;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChNine  = 8'h39;
    localparam logic [CharW-1:0] ChLowA  = 8'h61;
    localparam logic [CharW-1:0] ChLowF  = 8'h66;
    localparam logic [CharW-1:0] ChUpA   = 8'h41;
    localparam logic [CharW-1:0] ChUpF   = 8'h46;
    localparam logic [CharW-1:0] ChLowX  = 8'h78;
    localparam logic [CharW-1:0] ChUpX   = 8'h58;

    // Digit value that marks "not a digit of this base".
    localparam logic [4:0] DigitNone = 5'd16;
    localparam logic [4:0] DecBase   = 5'd10;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_ZERO  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_TRAIL = 3'd3,
        PH_ERR   = 3'd4
    } phase_t;

    // Parser state carried from one character to the next.
    typedef struct packed {
        phase_t            phase;
        logic [NumW-1:0]   accum;
        logic              hex_mode;
        logic              seen_digit;
    } parse_state_t;

    // One result word.
    typedef struct packed {
        logic              ok;
        logic [NumW-1:0]   number;
    } result_t;

    // Space, tab, carriage return or line feed.
    function automatic logic is_blank(input logic [CharW-1:0] c);
        return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
    endfunction

    // Digit value of c in the current base, or DigitNone.
    function automatic logic [4:0] digit_value(input logic [CharW-1:0] c,
                                               input logic hex);
        logic [4:0] d;
        d = DigitNone;
        if (c >= ChZero && c <= ChNine)
            d = 5'(c - ChZero);
        else if (hex && c >= ChLowA && c <= ChLowF)
            d = 5'(c - ChLowA) + 5'd10;
        else if (hex && c >= ChUpA && c <= ChUpF)
            d = 5'(c - ChUpA) + 5'd10;
        return d;
    endfunction

endpackage

>>> rtl/utp_char_if.sv
// Handshake channel that carries one string character per word.
// Depends on utp_pkg for the character width.
interface utp_char_if import utp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

>>> rtl/utp_result_if.sv
// Handshake channel that carries one parse result per word.
// Depends on utp_pkg for the number width.
interface utp_result_if import utp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            ok;
    logic [NumW-1:0] number;

    modport source (output valid, output ok, output number, input ready);
    modport sink   (input valid, input ok, input number, output ready);
endinterface

>>> rtl/utp_step.sv
// Combinational next-state and result logic for one character.
// Depends on utp_pkg for the state and result types and helper functions.
module utp_step
    import utp_pkg::*;
(
    input  parse_state_t     cur,
    input  logic [CharW-1:0] ch,
    output parse_state_t     nxt,
    output logic             is_end,
    output result_t          res
);

    logic             blank;
    logic [4:0]       dval;
    logic             dig_ok;
    logic             is_x;
    logic [NumW-1:0]  mac;
    phase_t           dig_phase;
    logic             valid_phase;

    // Character classification.
    assign is_end = (ch == ChNul);
    assign blank  = is_blank(ch);
    assign is_x   = (ch == ChLowX) || (ch == ChUpX);
    assign dval   = digit_value(ch, cur.hex_mode);
    assign dig_ok = cur.hex_mode ? (dval != DigitNone) : (dval < DecBase);

    // Multiply-accumulate by the base: shifts and adds only.
    assign mac = cur.hex_mode
               ? ((cur.accum << 4) + NumW'(dval))
               : ((cur.accum << 3) + (cur.accum << 1) + NumW'(dval));

    // Phase reached by a character handled as a digit-phase character.
    assign dig_phase = blank ? PH_TRAIL : (dig_ok ? PH_DIGIT : PH_ERR);

    // Next phase, accumulator, base and digit flag.
    always_comb
    begin
        nxt.phase      = PH_ERR;
        nxt.accum      = cur.accum;
        nxt.hex_mode   = cur.hex_mode;
        nxt.seen_digit = cur.seen_digit;
        if (is_end)
        begin
            nxt.phase = PH_LEAD;
        end
        else
        begin
            unique case (cur.phase)
                PH_LEAD:
                begin
                    if (blank)
                        nxt.phase = PH_LEAD;
                    else if (ch == ChZero)
                        nxt.phase = PH_ZERO;
                    else
                        nxt.phase = dig_phase;
                end
                PH_ZERO:  nxt.phase = is_x ? PH_DIGIT : dig_phase;
                PH_DIGIT: nxt.phase = dig_phase;
                PH_TRAIL: nxt.phase = blank ? PH_TRAIL : PH_ERR;
                default:  nxt.phase = PH_ERR;
            endcase
        end

        if (is_end)
        begin
            nxt.accum      = '0;
            nxt.hex_mode   = 1'b0;
            nxt.seen_digit = 1'b0;
        end
        else
        begin
            case (cur.phase)
                PH_LEAD:
                begin
                    if (!blank && ch == ChZero)
                    begin
                        nxt.accum      = '0;
                        nxt.seen_digit = 1'b1;
                    end
                    else if (!blank && dig_ok)
                    begin
                        nxt.accum      = mac;
                        nxt.seen_digit = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (is_x)
                    begin
                        nxt.hex_mode   = 1'b1;
                        nxt.seen_digit = 1'b0;
                        nxt.accum      = '0;
                    end
                    else if (!blank && dig_ok)
                    begin
                        nxt.accum      = mac;
                        nxt.seen_digit = 1'b1;
                    end
                end
                PH_DIGIT:
                begin
                    if (!blank && dig_ok)
                    begin
                        nxt.accum      = mac;
                        nxt.seen_digit = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result at the terminating zero byte.
    assign valid_phase = (cur.phase == PH_LEAD) || (cur.phase == PH_ZERO) ||
                         (cur.phase == PH_DIGIT) || (cur.phase == PH_TRAIL);
    assign res = (valid_phase && cur.seen_digit)
               ? result_t'{ok: 1'b1, number: cur.accum}
               : result_t'{ok: 1'b0, number: '0};

endmodule

>>> rtl/utp_out_reg.sv
// Result register that drives the output channel.
// Depends on utp_pkg for the result type and on utp_result_if.
module utp_out_reg
    import utp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_t      res,
    output logic         free,
    utp_result_if.source result_chan
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The register can take a new word when empty or being drained.
    assign free = !valid_reg || result_chan.ready;

    assign valid_next = load ? 1'b1 : (valid_reg && !result_chan.ready);

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign result_chan.valid  = valid_reg;
    assign result_chan.ok     = res_reg.ok;
    assign result_chan.number = res_reg.number;

endmodule

>>> rtl/uint32_text_parser.sv
// Top level of the streaming decimal/hex text to uint32 parser.
// Depends on utp_pkg, utp_char_if, utp_result_if, utp_step and utp_out_reg.
//
//   Channel      Dir  Payload                  Word
//   char_chan    in   char_in[7:0]             one string character
//   result_chan  out  ok, number[31:0]         one result per zero byte
//
// One character is taken per cycle unless a zero byte stalls on a full result
// register. A character is held in the input register, where the step logic
// updates the parser state; a zero byte held there also loads the result
// register, so its result word is valid once it has passed both registers.
// Reset clears the input and result valid flags and puts the parser in its
// leading-whitespace phase. Only a zero byte can stall on a full result
// register; other characters keep flowing while a result waits.
module uint32_text_parser
    import utp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    utp_char_if.sink   char_chan,
    utp_result_if.source result_chan
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [CharW-1:0] in_char_reg;
    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic             is_end;
    result_t          res;
    logic             out_free;
    logic             advance;
    logic             in_take;

    // The held character is consumed unless it is a zero byte facing a
    // full result register.
    assign advance = in_valid_reg && (!is_end || out_free);
    assign char_chan.ready = !in_valid_reg || advance;
    assign in_take = char_chan.valid && char_chan.ready;
    assign in_valid_next = in_take ? 1'b1 : (in_valid_reg && !advance);

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_char_reg <= char_chan.char_in;
    end

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_LEAD;
            state_reg.accum      <= '0;
            state_reg.hex_mode   <= 1'b0;
            state_reg.seen_digit <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    utp_step u_step (
        .cur    (state_reg),
        .ch     (in_char_reg),
        .nxt    (state_next),
        .is_end (is_end),
        .res    (res)
    );

    utp_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && is_end),
        .res         (res),
        .free        (out_free),
        .result_chan (result_chan)
    );

`ifndef SYNTHESIS
    // A consumed zero byte produces a result word on the next cycle.
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_end) |=> result_chan.valid)
        else $error("zero byte consumed without a result word");

    // A failed parse reports a zero number.
    a_fail_number_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && !result_chan.ok) |-> (result_chan.number == '0))
        else $error("failed parse with nonzero number");

    // After a zero byte the parser is back in its reset state.
    a_end_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_end) |=> (state_reg.phase == PH_LEAD &&
                                 !state_reg.seen_digit && !state_reg.hex_mode &&
                                 state_reg.accum == '0))
        else $error("parser state not cleared after end of string");
`endif

endmodule
